### rtl/gsfd_pkg.sv
package gsfd_pkg;

   localparam int unsigned POS_W = 5;

   // long line position that flags an attached keypad
   localparam logic [POS_W-1:0] KEYPAD_BIT = 5'd13;

   typedef struct packed {
      logic [11:0] short_buttons;
      logic [3:0]  short_directions;
      logic [23:0] long_buttons;
      logic [3:0]  long_directions;
      logic        keypad_present;
   } result_type;

   // long pad button masks, one per bit position
   localparam logic [23:0] LONG_BTN_MASK [32] = '{
      24'h000001, 24'h000004, 24'h000040, 24'h000080,
      24'h000000, 24'h000000, 24'h000000, 24'h000000,
      24'h000002, 24'h000008, 24'h000010, 24'h000020,
      24'h000000, 24'h000000, 24'h000000, 24'h000000,
      24'h000100, 24'h000200, 24'h000400, 24'h000800,
      24'h001000, 24'h002000, 24'h004000, 24'h008000,
      24'h010000, 24'h020000, 24'h040000, 24'h080000,
      24'h100000, 24'h200000, 24'h000000, 24'h800000
   };

   function automatic logic [11:0] mat_lower_mask(input logic [2:0] pos);
      logic [11:0] m;
      case (pos)
         3'd0:    m = 12'h008;
         3'd1:    m = 12'h004;
         3'd2:    m = 12'h800;
         3'd3:    m = 12'h080;
         default: m = 12'h000;
      endcase
      return m;
   endfunction

   function automatic logic [11:0] mat_middle_mask(input logic [2:0] pos);
      logic [11:0] m;
      case (pos)
         3'd0:    m = 12'h002;
         3'd1:    m = 12'h001;
         3'd2:    m = 12'h010;
         3'd3:    m = 12'h100;
         3'd4:    m = 12'h020;
         3'd5:    m = 12'h200;
         3'd6:    m = 12'h400;
         3'd7:    m = 12'h040;
         default: m = 12'h000;
      endcase
      return m;
   endfunction

   function automatic logic [11:0] short_btn_mask(input logic [2:0] pos);
      logic [11:0] m;
      case (pos)
         3'd0:    m = 12'h002;
         3'd1:    m = 12'h001;
         3'd2:    m = 12'h040;
         3'd3:    m = 12'h080;
         default: m = 12'h000;
      endcase
      return m;
   endfunction

endpackage

### rtl/gamepad_shift_frame_decoder_top.sv
// Serial game-pad frame decoder. Each accepted req word is one shift-clock
// sample of four active-low lines (two dance mat lines, the 8-bit pad line
// and the 16/32-bit pad line). req_frame_start marks bit 0 after a latch and
// clears the accumulators; samples outside a frame are dropped. A low level
// ORs fixed per-position masks into button and direction words. The frame
// closes after bit 13, or after bit FULL_FRAME_BITS-1 when the long line was
// low at bit 13 (keypad attached), and one rsp word carries the result.
// Rate: one sample per cycle while req_stall is low; the mask/OR update of the
// accumulators is a single level of logic from the sample to the state
// registers. The result sits in an output register backed by one skid
// register, so req_stall rises only when both hold an unread frame.
module gamepad_shift_frame_decoder_top
   import gsfd_pkg::*;
#(
   parameter int unsigned FULL_FRAME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_frame_start,
   input  logic        req_mat_lower_level,
   input  logic        req_mat_middle_level,
   input  logic        req_short_pad_level,
   input  logic        req_long_pad_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_short_buttons,
   output logic [3:0]  rsp_short_directions,
   output logic [23:0] rsp_long_buttons,
   output logic [3:0]  rsp_long_directions,
   output logic        rsp_keypad_present
);

   // last bit position of a frame with the keypad attached
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FULL_FRAME_BITS - 1);

   // frame state
   logic [POS_W-1:0] bit_position_ff, bit_position_in;
   logic             frame_active_ff, frame_active_in;
   logic             keypad_seen_ff, keypad_seen_in;
   logic [11:0]      short_button_acc_ff, short_button_acc_in;
   logic [3:0]       short_direction_acc_ff, short_direction_acc_in;
   logic [23:0]      long_button_acc_ff, long_button_acc_in;
   logic [3:0]       long_direction_acc_ff, long_direction_acc_in;

   // output register and skid register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff, skid_data_in;

   logic             accept;
   logic             active;
   logic [POS_W-1:0] pos;
   logic [3:0]       dir_bit;
   logic             frame_done;
   result_type       new_result;
   logic             new_valid;
   logic             take;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign take      = rsp_valid_ff && !rsp_stall;

   // sample decode and accumulate
   always_comb begin
      logic [11:0] sbtn;
      logic [3:0]  sdir;
      logic [23:0] lbtn;
      logic [3:0]  ldir;
      logic        kpad;

      active  = req_frame_start || frame_active_ff;
      pos     = req_frame_start ? '0 : bit_position_ff;
      sbtn    = req_frame_start ? '0 : short_button_acc_ff;
      sdir    = req_frame_start ? '0 : short_direction_acc_ff;
      lbtn    = req_frame_start ? '0 : long_button_acc_ff;
      ldir    = req_frame_start ? '0 : long_direction_acc_ff;
      kpad    = req_frame_start ? 1'b0 : keypad_seen_ff;
      dir_bit = 4'b0001 << pos[1:0];

      // short and mat lines only count in bits 0..7
      if (pos < POS_W'(8)) begin
         if (!req_mat_lower_level) begin
            sbtn = sbtn | mat_lower_mask(pos[2:0]);
         end
         if (!req_mat_middle_level) begin
            sbtn = sbtn | mat_middle_mask(pos[2:0]);
         end
         if (!req_short_pad_level) begin
            if (pos[2]) begin
               sdir = sdir | dir_bit;
            end else begin
               sbtn = sbtn | short_btn_mask(pos[2:0]);
            end
         end
      end

      if (!req_long_pad_level) begin
         if (pos == KEYPAD_BIT) begin
            kpad = 1'b1;
         end
         if (pos[4:2] == 3'b001) begin
            ldir = ldir | dir_bit;
         end else begin
            lbtn = lbtn | LONG_BTN_MASK[pos];
         end
      end

      frame_done = kpad ? (pos >= LAST_POS) : (pos >= KEYPAD_BIT);

      bit_position_in        = bit_position_ff;
      frame_active_in        = frame_active_ff;
      keypad_seen_in         = keypad_seen_ff;
      short_button_acc_in    = short_button_acc_ff;
      short_direction_acc_in = short_direction_acc_ff;
      long_button_acc_in     = long_button_acc_ff;
      long_direction_acc_in  = long_direction_acc_ff;
      new_valid              = 1'b0;

      if (accept && active) begin
         keypad_seen_in         = kpad;
         short_button_acc_in    = sbtn;
         short_direction_acc_in = sdir;
         long_button_acc_in     = lbtn;
         long_direction_acc_in  = ldir;
         if (frame_done) begin
            bit_position_in = '0;
            frame_active_in = 1'b0;
            new_valid       = 1'b1;
         end else begin
            bit_position_in = pos + POS_W'(1);
            frame_active_in = 1'b1;
         end
      end

      new_result.short_buttons    = sbtn;
      new_result.short_directions = sdir;
      new_result.long_buttons     = lbtn;
      new_result.long_directions  = ldir;
      new_result.keypad_present   = kpad;
   end

   // output register with skid
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // no accept possible here: req is stalled
         if (take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (new_valid) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = new_result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = new_result;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_position_ff        <= '0;
         frame_active_ff        <= 1'b0;
         keypad_seen_ff         <= 1'b0;
         short_button_acc_ff    <= '0;
         short_direction_acc_ff <= '0;
         long_button_acc_ff     <= '0;
         long_direction_acc_ff  <= '0;
         rsp_valid_ff           <= 1'b0;
         skid_valid_ff          <= 1'b0;
      end else begin
         bit_position_ff        <= bit_position_in;
         frame_active_ff        <= frame_active_in;
         keypad_seen_ff         <= keypad_seen_in;
         short_button_acc_ff    <= short_button_acc_in;
         short_direction_acc_ff <= short_direction_acc_in;
         long_button_acc_ff     <= long_button_acc_in;
         long_direction_acc_ff  <= long_direction_acc_in;
         rsp_valid_ff           <= rsp_valid_in;
         skid_valid_ff          <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_short_buttons    = rsp_data_ff.short_buttons;
   assign rsp_short_directions = rsp_data_ff.short_directions;
   assign rsp_long_buttons     = rsp_data_ff.long_buttons;
   assign rsp_long_directions  = rsp_data_ff.long_directions;
   assign rsp_keypad_present   = rsp_data_ff.keypad_present;

   // skid only fills behind a held output word
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word without output word");

   // idle decoder parks at bit 0
   a_idle_pos: assert property (@(posedge clock) disable iff (reset)
      !frame_active_ff |-> bit_position_ff == '0)
      else $error("bit position not cleared when idle");

   // keypad flag set only once bit 13 has passed
   a_keypad_pos: assert property (@(posedge clock) disable iff (reset)
      (frame_active_ff && keypad_seen_ff) |-> bit_position_ff > KEYPAD_BIT)
      else $error("keypad flag before bit 13");

   // short frame never runs past bit 13
   a_short_frame: assert property (@(posedge clock) disable iff (reset)
      (frame_active_ff && !keypad_seen_ff) |-> bit_position_ff <= KEYPAD_BIT)
      else $error("frame without keypad ran past bit 13");

endmodule

### tb/tb_gamepad_shift_frame_decoder_top.sv
module tb_gamepad_shift_frame_decoder_top;
   import gsfd_pkg::result_type;

   // Frame geometry as this bench expects it: the keypad flag sits on the long
   // line at bit 13, a frame without keypad is 14 bits long.
   localparam int unsigned FRAME_BITS   = 32;
   localparam int unsigned KEYPAD_POS   = 13;
   localparam int unsigned SHORT_FRAME  = KEYPAD_POS + 1;
   localparam int unsigned RANDOM_ITEMS = 660;
   // output side held off this long once, so the result register, the skid
   // register and then req_stall all fill up
   localparam int unsigned HOLD_CYCLES  = 600;
   localparam int unsigned TAIL_CYCLES  = 40;
   localparam int unsigned CYCLE_LIMIT  = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_frame_start = 1'b0;
   logic        req_mat_lower_level = 1'b1;
   logic        req_mat_middle_level = 1'b1;
   logic        req_short_pad_level = 1'b1;
   logic        req_long_pad_level = 1'b1;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_short_buttons;
   logic [3:0]  rsp_short_directions;
   logic [23:0] rsp_long_buttons;
   logic [3:0]  rsp_long_directions;
   logic        rsp_keypad_present;

   // Predicts decoded frames from accepted samples and checks rsp words
   // against them in order.
   class pad_frame_scoreboard;
      int unsigned frame_bits;
      logic [4:0]  bit_pos;
      bit          in_frame;
      bit          keypad;
      logic [11:0] short_btn;
      logic [3:0]  short_dir;
      logic [23:0] long_btn;
      logic [3:0]  long_dir;
      result_type  expected_frames[$];
      int unsigned mismatches;
      int unsigned frames_checked;
      int unsigned samples_used;
      int unsigned samples_dropped;
      int unsigned keypad_frames;

      function new(int unsigned full_bits);
         frame_bits = full_bits;
         in_frame   = 1'b0;
         restart();
      endfunction

      function void restart();
         bit_pos   = '0;
         keypad    = 1'b0;
         short_btn = '0;
         short_dir = '0;
         long_btn  = '0;
         long_dir  = '0;
      endfunction

      function int unsigned pending();
         return expected_frames.size();
      endfunction

      function logic [11:0] mat_lower_bits(logic [2:0] p);
         case (p)
            3'd0:    return 12'h008;
            3'd1:    return 12'h004;
            3'd2:    return 12'h800;
            3'd3:    return 12'h080;
            default: return 12'h000;
         endcase
      endfunction

      function logic [11:0] mat_middle_bits(logic [2:0] p);
         case (p)
            3'd0:    return 12'h002;
            3'd1:    return 12'h001;
            3'd2:    return 12'h010;
            3'd3:    return 12'h100;
            3'd4:    return 12'h020;
            3'd5:    return 12'h200;
            3'd6:    return 12'h400;
            default: return 12'h040;
         endcase
      endfunction

      function logic [11:0] short_btn_bits(logic [2:0] p);
         case (p)
            3'd0:    return 12'h002;
            3'd1:    return 12'h001;
            3'd2:    return 12'h040;
            3'd3:    return 12'h080;
            default: return 12'h000;
         endcase
      endfunction

      // bits 16..29 walk up from 0x100; 12..15 and 30 carry nothing
      function logic [23:0] long_btn_bits(logic [4:0] p);
         if (p >= 5'd16 && p <= 5'd29)
            return 24'h000100 << (p - 5'd16);
         case (p)
            5'd0:    return 24'h000001;
            5'd1:    return 24'h000004;
            5'd2:    return 24'h000040;
            5'd3:    return 24'h000080;
            5'd8:    return 24'h000002;
            5'd9:    return 24'h000008;
            5'd10:   return 24'h000010;
            5'd11:   return 24'h000020;
            5'd31:   return 24'h800000;
            default: return 24'h000000;
         endcase
      endfunction

      function void take_sample(logic start, logic lower, logic middle,
                                logic short_lvl, logic long_lvl);
         result_type frame;
         bit         done;
         if (start) begin
            restart();
            in_frame = 1'b1;
         end
         if (!in_frame) begin
            samples_dropped++;
            return;
         end
         samples_used++;
         if (bit_pos < 8) begin
            if (!lower)
               short_btn |= mat_lower_bits(bit_pos[2:0]);
            if (!middle)
               short_btn |= mat_middle_bits(bit_pos[2:0]);
            if (!short_lvl) begin
               if (bit_pos >= 4)
                  short_dir[bit_pos[1:0]] = 1'b1;
               else
                  short_btn |= short_btn_bits(bit_pos[2:0]);
            end
         end
         if (!long_lvl) begin
            if (bit_pos == KEYPAD_POS)
               keypad = 1'b1;
            if (bit_pos >= 4 && bit_pos < 8)
               long_dir[bit_pos[1:0]] = 1'b1;
            else
               long_btn |= long_btn_bits(bit_pos);
         end
         done = keypad ? (bit_pos >= frame_bits - 1) : (bit_pos >= KEYPAD_POS);
         if (!done) begin
            bit_pos++;
            return;
         end
         frame.short_buttons    = short_btn;
         frame.short_directions = short_dir;
         frame.long_buttons     = long_btn;
         frame.long_directions  = long_dir;
         frame.keypad_present   = keypad;
         expected_frames.push_back(frame);
         if (keypad)
            keypad_frames++;
         in_frame = 1'b0;
         bit_pos  = '0;
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task compare_field(string name, logic [23:0] got, logic [23:0] want);
         if (got !== want)
            report_mismatch($sformatf("frame %0d %s: got 0x%0h, expected 0x%0h",
                                      frames_checked, name, got, want));
      endtask

      task check_frame(result_type got);
         result_type want;
         if (expected_frames.size() == 0) begin
            report_mismatch($sformatf("frame word 0x%0h with none expected", got));
            return;
         end
         want = expected_frames.pop_front();
         compare_field("short_buttons", 24'(got.short_buttons),
                       24'(want.short_buttons));
         compare_field("short_directions", 24'(got.short_directions),
                       24'(want.short_directions));
         compare_field("long_buttons", got.long_buttons, want.long_buttons);
         compare_field("long_directions", 24'(got.long_directions),
                       24'(want.long_directions));
         compare_field("keypad_present", 24'(got.keypad_present),
                       24'(want.keypad_present));
         frames_checked++;
      endtask
   endclass

   pad_frame_scoreboard pad_frames;

   int unsigned cycle_count = 0;
   int unsigned frame_samples = 0;
   int unsigned input_stall_cycles = 0;
   bit          tx_quiet = 1'b0;  // sender stretch with no gaps
   bit          tx_burst = 1'b0;  // forced back-to-back words
   bit          rx_quiet = 1'b0;  // receiver stretch with no stalls
   int unsigned rx_wait = 0;
   bit          hold_req = 1'b0;
   logic        rsp_hold = 1'b0;

   gamepad_shift_frame_decoder_top #(
      .FULL_FRAME_BITS(FRAME_BITS)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_frame_start     (req_frame_start),
      .req_mat_lower_level (req_mat_lower_level),
      .req_mat_middle_level(req_mat_middle_level),
      .req_short_pad_level (req_short_pad_level),
      .req_long_pad_level  (req_long_pad_level),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_short_buttons   (rsp_short_buttons),
      .rsp_short_directions(rsp_short_directions),
      .rsp_long_buttons    (rsp_long_buttons),
      .rsp_long_directions (rsp_long_directions),
      .rsp_keypad_present  (rsp_keypad_present)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle/stall length per word: often none, often short, sometimes up to 16.
   function automatic int unsigned pick_wait();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return $urandom_range(0, 3);
         default: return $urandom_range(0, 16);
      endcase
   endfunction

   // Line levels for one frame: sparse presses, dense presses, all released
   // or plain random.
   function automatic logic [31:0] line_levels();
      case ($urandom_range(0, 3))
         0:       return $urandom | $urandom;
         1:       return $urandom & $urandom;
         2:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Output side: after each accepted word, stall for a drawn number of
   // cycles. rsp_hold (long hold-off window) overrides everything.
   always @(posedge clock) begin
      if (reset) begin
         rx_wait = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if ($urandom_range(0, 7) == 0)
               rx_quiet = !rx_quiet;
            rx_wait = rx_quiet ? 0 : pick_wait();
         end else if (rx_wait > 0) begin
            rx_wait--;
         end
         rsp_stall <= (rx_wait > 0) || rsp_hold;
      end
   end

   // Long hold-off, counted here so the sender keeps going meanwhile.
   initial begin
      wait (hold_req);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Both channels sampled on the edge; every value read here is the one
   // from before the edge, so process order within the step does not matter.
   always @(posedge clock) begin : word_monitor
      result_type got;
      if (!reset) begin
         if (req_valid && req_stall)
            input_stall_cycles++;
         if (req_valid && !req_stall)
            pad_frames.take_sample(req_frame_start, req_mat_lower_level,
                                   req_mat_middle_level, req_short_pad_level,
                                   req_long_pad_level);
         if (rsp_valid && !rsp_stall) begin
            got.short_buttons    = rsp_short_buttons;
            got.short_directions = rsp_short_directions;
            got.long_buttons     = rsp_long_buttons;
            got.long_directions  = rsp_long_directions;
            got.keypad_present   = rsp_keypad_present;
            pad_frames.check_frame(got);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d frames still outstanding",
                  cycle_count, pad_frames.pending());
         $display("** gamepad_shift_frame_decoder_top: FAILED **");
         $finish;
      end
   end

   // Offers one sample word after a drawn gap and returns in the step in
   // which it was accepted; valid is left high so a zero gap follows on.
   task automatic send_sample(input logic start, lower, middle, short_lvl, long_lvl);
      int unsigned gap;
      if ($urandom_range(0, 19) == 0)
         tx_quiet = !tx_quiet;
      gap = (tx_quiet || tx_burst) ? 0 : pick_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_frame_start      <= start;
      req_mat_lower_level  <= lower;
      req_mat_middle_level <= middle;
      req_short_pad_level  <= short_lvl;
      req_long_pad_level   <= long_lvl;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Bit b of each vector is the line level at frame position b.
   task automatic send_frame(input logic [31:0] lower, middle, short_lvl, long_lvl,
                             input int unsigned nbits);
      for (int b = 0; b < nbits; b++)
         send_sample(b == 0, lower[b], middle[b], short_lvl[b], long_lvl[b]);
      frame_samples += nbits;
   endtask

   task automatic send_random_frame(input bit truncate);
      logic [31:0] lower, middle, short_lvl, long_lvl;
      int unsigned nbits;
      lower     = line_levels();
      middle    = line_levels();
      short_lvl = line_levels();
      long_lvl  = line_levels();
      long_lvl[KEYPAD_POS] = 1'($urandom_range(0, 1));
      nbits = long_lvl[KEYPAD_POS] ? SHORT_FRAME : FRAME_BITS;
      // cut short: the next frame_start drops the partial frame
      if (truncate)
         nbits = $urandom_range(1, nbits - 1);
      send_frame(lower, middle, short_lvl, long_lvl, nbits);
   endtask

   // one edge first so the monitor has logged the last accepted sample
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pad_frames.pending() != 0)
         @(posedge clock);
   endtask

   initial begin
      pad_frames = new(FRAME_BITS);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: samples outside a frame are dropped, a restart mid-frame
      // discards the partial frame, then a short frame with every line
      // pressed except the keypad bit (short/mat lines pressed past bit 7).
      send_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_sample(1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
      send_frame('0, '0, '0, '0, 5);
      send_frame('0, '0, '0, 32'h0000_2000, SHORT_FRAME);

      // Output held off while words go in back to back: both result
      // registers fill and req_stall must rise. The first two frames are the
      // keypad extremes: all pressed (bit 13 and the dead long positions add
      // no button), and all released but the keypad bit.
      hold_req = 1'b1;
      tx_burst = 1'b1;
      send_frame('0, '0, '0, '0, FRAME_BITS);
      send_frame('1, '1, '1, ~(32'h1 << KEYPAD_POS), FRAME_BITS);
      repeat (4)
         send_random_frame(1'b0);
      tx_burst = 1'b0;
      wait_drained();

      // Random: mostly whole frames, some cut short, some stray samples
      // (an occasional stray frame_start among them), and now and then a
      // pause until every frame is out.
      frame_samples = 0;
      while (frame_samples < RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0:       wait_drained();
            1, 2:    repeat ($urandom_range(1, 4))
                        send_sample($urandom_range(0, 7) == 0,
                                    1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)));
            3, 4:    send_random_frame(1'b1);
            default: send_random_frame(1'b0);
         endcase
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d in-frame samples, %0d dropped idle samples, %0d input stall cycles",
               pad_frames.samples_used, pad_frames.samples_dropped, input_stall_cycles);
      $display("checked %0d decoded frames (%0d with keypad), %0d mismatches",
               pad_frames.frames_checked, pad_frames.keypad_frames, pad_frames.mismatches);
      if (pad_frames.mismatches == 0)
         $display("** gamepad_shift_frame_decoder_top: PASSED **");
      else
         $display("** gamepad_shift_frame_decoder_top: FAILED **");
      $finish;
   end

endmodule

### gamepad_shift_frame_decoder_top.f
rtl/gsfd_pkg.sv
rtl/gamepad_shift_frame_decoder_top.sv
tb/tb_gamepad_shift_frame_decoder_top.sv
